// ===== rtl/sct_pkg.sv =====
// ----------------------------------------------------------------------------
// sct_pkg
// Shared types and constants for the scissor clip of textured rectangles.
// ----------------------------------------------------------------------------
`default_nettype none

package sct_pkg;

  localparam int POS_BITS   = 16;
  localparam int TEX_BITS   = 16;
  localparam int DIV_STEPS  = 4;
  localparam int DIV_STAGES = TEX_BITS / DIV_STEPS;
  // clip, setup, multiply, divide stages, output
  localparam int NSTG       = DIV_STAGES + 4;
  localparam int CFG_IDX_W  = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE,
    CFG_LEFT,
    CFG_TOP,
    CFG_RIGHT,
    CFG_BOTTOM
  } cfg_idx_e;

  typedef struct packed {
    logic signed [POS_BITS-1:0] ul_x;
    logic signed [POS_BITS-1:0] ul_y;
    logic signed [POS_BITS-1:0] lr_x;
    logic signed [POS_BITS-1:0] lr_y;
    logic signed [TEX_BITS-1:0] ul_s;
    logic signed [TEX_BITS-1:0] ul_t;
    logic signed [TEX_BITS-1:0] lr_s;
    logic signed [TEX_BITS-1:0] lr_t;
  } in_t;

  typedef struct packed {
    logic                       visible;
    logic signed [POS_BITS-1:0] out_ul_x;
    logic signed [POS_BITS-1:0] out_ul_y;
    logic signed [POS_BITS-1:0] out_lr_x;
    logic signed [POS_BITS-1:0] out_lr_y;
    logic signed [TEX_BITS-1:0] out_ul_s;
    logic signed [TEX_BITS-1:0] out_ul_t;
    logic signed [TEX_BITS-1:0] out_lr_s;
    logic signed [TEX_BITS-1:0] out_lr_t;
  } out_t;

  typedef struct packed {
    logic                       clip;
    logic                       vis;
    logic signed [POS_BITS-1:0] ox_ul;
    logic signed [POS_BITS-1:0] oy_ul;
    logic signed [POS_BITS-1:0] ox_lr;
    logic signed [POS_BITS-1:0] oy_lr;
    in_t                        raw;
  } side_t;

endpackage

`default_nettype wire

// ===== rtl/scissor_clip_textured_rect_top.sv =====
// ----------------------------------------------------------------------------
// scissor_clip_textured_rect_top
// Clips rectangles against a scissor box and re-interpolates texcoords.
//
//   channel | dir | handshake           | beat
//   in      | in  | in_valid / in_stall | in_t rectangle
//   out     | out | out_valid/out_stall | out_t clipped rectangle
//   cfg     | in  | cfg_valid/cfg_ready | register index + data
//
// One rectangle per cycle sustained while out_stall_i is low; stages: clip,
// setup, 16x16 multiply, four divide stages of four quotient bits, output.
// Each stage advances when empty or when the next one advances, so bubbles
// collapse under a stall. Reset clears valid bits and scissor registers.
// ----------------------------------------------------------------------------
`default_nettype none

module scissor_clip_textured_rect_top import sct_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire in_t                  in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output out_t                      out_data_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [POS_BITS-1:0]  cfg_data_i
);

  logic                       en_q;
  logic signed [POS_BITS-1:0] left_q, top_q, right_q, bottom_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q     <= 1'b0;
      left_q   <= '0;
      top_q    <= '0;
      right_q  <= '0;
      bottom_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_ENABLE: en_q     <= cfg_data_i[0];
        CFG_LEFT:   left_q   <= cfg_data_i;
        CFG_TOP:    top_q    <= cfg_data_i;
        CFG_RIGHT:  right_q  <= cfg_data_i;
        CFG_BOTTOM: bottom_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // stage advance
  logic [NSTG-1:0] v_q, v_d, adv;

  always_comb begin
    adv[NSTG-1] = !v_q[NSTG-1] || !out_stall_i;
    for (int k = NSTG-2; k >= 0; k--) begin
      adv[k] = !v_q[k] || adv[k+1];
    end
    v_d[0] = adv[0] ? in_valid_i : v_q[0];
    for (int k = 1; k < NSTG; k++) begin
      v_d[k] = adv[k] ? v_q[k-1] : v_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign in_stall_o  = !adv[0];
  assign out_valid_o = v_q[NSTG-1];

  // clip
  side_t side_d;
  side_t side_q [NSTG-1];

  always_comb begin
    side_d.clip  = en_q;
    side_d.raw   = in_data_i;
    side_d.ox_ul = (left_q > in_data_i.ul_x) ? left_q : in_data_i.ul_x;
    side_d.oy_ul = (top_q > in_data_i.ul_y) ? top_q : in_data_i.ul_y;
    side_d.ox_lr = (right_q <= in_data_i.lr_x) ? right_q : in_data_i.lr_x;
    side_d.oy_lr = (bottom_q <= in_data_i.lr_y) ? bottom_q : in_data_i.lr_y;
    side_d.vis   = !en_q || !((side_d.ox_ul > side_d.ox_lr) || (side_d.oy_ul > side_d.oy_lr));
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      side_q[0] <= side_d;
    end
    for (int k = 1; k < NSTG-1; k++) begin
      if (adv[k]) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  logic signed [TEX_BITS-1:0] r_ul_s, r_ul_t, r_lr_s, r_lr_t;

  sct_lane u_ul_s (
    .clk_i, .en_i(adv[NSTG-2:1]), .v_i(side_q[0].ox_ul), .mn_i(side_q[0].raw.ul_x),
    .mx_i(side_q[0].raw.lr_x), .t0_i(side_q[0].raw.ul_s), .t1_i(side_q[0].raw.lr_s),
    .res_o(r_ul_s)
  );
  sct_lane u_ul_t (
    .clk_i, .en_i(adv[NSTG-2:1]), .v_i(side_q[0].oy_ul), .mn_i(side_q[0].raw.ul_y),
    .mx_i(side_q[0].raw.lr_y), .t0_i(side_q[0].raw.ul_t), .t1_i(side_q[0].raw.lr_t),
    .res_o(r_ul_t)
  );
  sct_lane u_lr_s (
    .clk_i, .en_i(adv[NSTG-2:1]), .v_i(side_q[0].ox_lr), .mn_i(side_q[0].raw.ul_x),
    .mx_i(side_q[0].raw.lr_x), .t0_i(side_q[0].raw.ul_s), .t1_i(side_q[0].raw.lr_s),
    .res_o(r_lr_s)
  );
  sct_lane u_lr_t (
    .clk_i, .en_i(adv[NSTG-2:1]), .v_i(side_q[0].oy_lr), .mn_i(side_q[0].raw.ul_y),
    .mx_i(side_q[0].raw.lr_y), .t0_i(side_q[0].raw.ul_t), .t1_i(side_q[0].raw.lr_t),
    .res_o(r_lr_t)
  );

  // output select
  side_t sl;
  out_t  out_d, out_q;

  always_comb begin
    sl = side_q[NSTG-2];
    if (!sl.clip) begin
      out_d = '{visible: 1'b1, out_ul_x: sl.raw.ul_x, out_ul_y: sl.raw.ul_y,
                out_lr_x: sl.raw.lr_x, out_lr_y: sl.raw.lr_y, out_ul_s: sl.raw.ul_s,
                out_ul_t: sl.raw.ul_t, out_lr_s: sl.raw.lr_s, out_lr_t: sl.raw.lr_t};
    end else if (!sl.vis) begin
      out_d = '0;
    end else begin
      out_d = '{visible: 1'b1, out_ul_x: sl.ox_ul, out_ul_y: sl.oy_ul,
                out_lr_x: sl.ox_lr, out_lr_y: sl.oy_lr, out_ul_s: r_ul_s,
                out_ul_t: r_ul_t, out_lr_s: r_lr_s, out_lr_t: r_lr_t};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[NSTG-1]) begin
      out_q <= out_d;
    end
  end

  assign out_data_o = out_q;

  // checks
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (&v_q && out_stall_i) |-> in_stall_o)
    else $error("accepted a beat with a full, stalled pipe");

  a_invis_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.visible) |-> (out_data_o == '0))
    else $error("invisible result with nonzero fields");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result changed");

  a_no_stall_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!v_q[0]) |-> !in_stall_o)
    else $error("stall with empty entry stage");

endmodule

`default_nettype wire

// ===== rtl/sct_lane.sv =====
// ----------------------------------------------------------------------------
// sct_lane
// One texture coordinate re-interpolation lane: setup, multiply, pipelined
// restoring divide with round half away from zero, then add and saturate.
// ----------------------------------------------------------------------------
`default_nettype none

module sct_lane import sct_pkg::*; (
  input  wire logic                       clk_i,
  input  wire logic [NSTG-2:1]            en_i,
  input  wire logic signed [POS_BITS-1:0] v_i,
  input  wire logic signed [POS_BITS-1:0] mn_i,
  input  wire logic signed [POS_BITS-1:0] mx_i,
  input  wire logic signed [TEX_BITS-1:0] t0_i,
  input  wire logic signed [TEX_BITS-1:0] t1_i,
  output logic signed [TEX_BITS-1:0]      res_o
);

  localparam int PW = POS_BITS + TEX_BITS;
  localparam logic signed [TEX_BITS+1:0] TMAX = (TEX_BITS+2)'((1 << (TEX_BITS-1)) - 1);
  localparam logic signed [TEX_BITS+1:0] TMIN = -TMAX - (TEX_BITS+2)'(1);

  typedef struct packed {
    logic [POS_BITS-1:0]        rem;
    logic [TEX_BITS-1:0]        low;
    logic [TEX_BITS-1:0]        quo;
    logic [POS_BITS-1:0]        den;
    logic                       neg;
    logic signed [TEX_BITS-1:0] t0;
  } div_t;

  // setup
  logic signed [TEX_BITS:0] dt;
  logic signed [POS_BITS:0] num, den;
  logic                     zero;
  logic [TEX_BITS-1:0]      a_d, a_q;
  logic [POS_BITS-1:0]      b_d, b_q, d1_q, d2_q;
  logic                     neg1_q, neg2_q;
  logic signed [TEX_BITS-1:0] t01_q, t02_q;
  logic [PW-1:0]            p_q;

  always_comb begin
    zero = (mx_i == mn_i);
    dt   = {t1_i[TEX_BITS-1], t1_i} - {t0_i[TEX_BITS-1], t0_i};
    num  = zero ? (POS_BITS+1)'(1) : ({v_i[POS_BITS-1], v_i} - {mn_i[POS_BITS-1], mn_i});
    den  = zero ? (POS_BITS+1)'(2) : ({mx_i[POS_BITS-1], mx_i} - {mn_i[POS_BITS-1], mn_i});
    a_d  = dt[TEX_BITS] ? TEX_BITS'(-dt) : dt[TEX_BITS-1:0];
    b_d  = num[POS_BITS] ? POS_BITS'(-num) : num[POS_BITS-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      a_q    <= a_d;
      b_q    <= b_d;
      d1_q   <= den[POS_BITS] ? POS_BITS'(-den) : den[POS_BITS-1:0];
      neg1_q <= dt[TEX_BITS] ^ num[POS_BITS] ^ den[POS_BITS];
      t01_q  <= t0_i;
    end
    if (en_i[2]) begin
      p_q    <= PW'(a_q) * PW'(b_q);
      d2_q   <= d1_q;
      neg2_q <= neg1_q;
      t02_q  <= t01_q;
    end
  end

  // divide
  div_t div_in [DIV_STAGES];
  div_t div_q  [DIV_STAGES];

  assign div_in[0] = '{rem: p_q[PW-1:TEX_BITS], low: p_q[TEX_BITS-1:0], quo: '0,
                       den: d2_q, neg: neg2_q, t0: t02_q};

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    div_t nx;
    if (k > 0) begin : g_link
      assign div_in[k] = div_q[k-1];
    end

    always_comb begin
      logic [POS_BITS:0] tr;
      logic              ge;
      nx = div_in[k];
      for (int i = 0; i < DIV_STEPS; i++) begin
        tr     = {nx.rem, nx.low[TEX_BITS-1]};
        nx.low = {nx.low[TEX_BITS-2:0], 1'b0};
        ge     = (tr >= {1'b0, nx.den});
        if (ge) begin
          tr = tr - {1'b0, nx.den};
        end
        nx.rem = tr[POS_BITS-1:0];
        nx.quo = {nx.quo[TEX_BITS-2:0], ge};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i[3+k]) begin
        div_q[k] <= nx;
      end
    end
  end

  // round, add, saturate
  div_t                     fin;
  logic                     rnd;
  logic [TEX_BITS:0]        qq;
  logic signed [TEX_BITS+1:0] sum, t0e;

  always_comb begin
    fin = div_q[DIV_STAGES-1];
    rnd = ({fin.rem, 1'b0} >= {1'b0, fin.den});
    qq  = {1'b0, fin.quo} + (TEX_BITS+1)'(rnd);
    t0e = {{2{fin.t0[TEX_BITS-1]}}, fin.t0};
    sum = fin.neg ? (t0e - $signed({1'b0, qq})) : (t0e + $signed({1'b0, qq}));
    if (sum > TMAX) begin
      res_o = TMAX[TEX_BITS-1:0];
    end else if (sum < TMIN) begin
      res_o = TMIN[TEX_BITS-1:0];
    end else begin
      res_o = sum[TEX_BITS-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/tb_scissor_clip_textured_rect_top.sv =====
// ----------------------------------------------------------------------------
// tb_scissor_clip_textured_rect_top
// Self-checking bench for the scissor clip of textured rectangles.
// Drives rectangles under several scissor settings, predicts each clipped
// rectangle and its re-interpolated texcoords, and checks every output beat
// in order. Random idle gaps and output stalls run on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_scissor_clip_textured_rect_top;
  import sct_pkg::*;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  in_t                  in_data_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  out_t                 out_data_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [POS_BITS-1:0]  cfg_data_i = '0;

  scissor_clip_textured_rect_top u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_idx_i, .cfg_data_i
  );

  // scissor state mirrored in the bench
  logic                       sc_en;
  logic signed [POS_BITS-1:0] sc_left, sc_top, sc_right, sc_bottom;

  out_t clip_q[$];
  int   errors = 0;
  int   n_sent = 0;
  int   n_checked = 0;
  int   n_hidden = 0;
  bit   idle_on = 1'b1;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #60_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic logic signed [TEX_BITS-1:0] lerp_tex(
    longint v, longint mn, longint mx, longint t0, longint t1);
    longint dt, num, den, p, q, r, hi, lo;
    bit neg;
    dt = t1 - t0;
    num = 1;
    den = 2;
    if (mx != mn) begin
      num = v - mn;
      den = mx - mn;
    end
    p = dt * num;
    neg = (p < 0) != (den < 0);
    if (p < 0) p = -p;
    if (den < 0) den = -den;
    q = (2 * p + den) / (2 * den);
    r = neg ? t0 - q : t0 + q;
    hi = (longint'(1) << (TEX_BITS - 1)) - 1;
    lo = -hi - 1;
    if (r > hi) r = hi;
    if (r < lo) r = lo;
    return r[TEX_BITS-1:0];
  endfunction

  function automatic out_t clip_rect(in_t a);
    out_t   o;
    longint ux, uy, lx, ly;
    o = '0;
    if (!sc_en) begin
      o = {1'b1, a};
    end else begin
      ux = (sc_left > a.ul_x) ? sc_left : a.ul_x;
      lx = (sc_right <= a.lr_x) ? sc_right : a.lr_x;
      uy = (sc_top > a.ul_y) ? sc_top : a.ul_y;
      ly = (sc_bottom <= a.lr_y) ? sc_bottom : a.lr_y;
      if (ux <= lx && uy <= ly) begin
        o.visible  = 1'b1;
        o.out_ul_x = ux[POS_BITS-1:0];
        o.out_ul_y = uy[POS_BITS-1:0];
        o.out_lr_x = lx[POS_BITS-1:0];
        o.out_lr_y = ly[POS_BITS-1:0];
        o.out_ul_s = lerp_tex(ux, a.ul_x, a.lr_x, a.ul_s, a.lr_s);
        o.out_ul_t = lerp_tex(uy, a.ul_y, a.lr_y, a.ul_t, a.lr_t);
        o.out_lr_s = lerp_tex(lx, a.ul_x, a.lr_x, a.ul_s, a.lr_s);
        o.out_lr_t = lerp_tex(ly, a.ul_y, a.lr_y, a.ul_t, a.lr_t);
      end
    end
    return o;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (!idle_on || r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // output stall
  always @(posedge clk_i) begin
    if (!idle_on) out_stall_i <= 1'b0;
    else if ($urandom_range(0, 39) == 0) out_stall_i <= 1'b1;
    else if ($urandom_range(0, 3) == 0) out_stall_i <= ~out_stall_i;
  end

  // result checker
  always @(posedge clk_i) begin
    out_t exp_o;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (clip_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat %h", $time, out_data_o);
      end else begin
        exp_o = clip_q.pop_front();
        n_checked++;
        if (!exp_o.visible) n_hidden++;
        if (out_data_o.visible !== exp_o.visible) begin
          errors++;
          $display("%0t: visible exp %b act %b", $time, exp_o.visible, out_data_o.visible);
        end
        for (int k = 0; k < 8; k++) begin
          if (out_data_o[127-16*k -: 16] !== exp_o[127-16*k -: 16]) begin
            errors++;
            $display("%0t: field %0d exp %h act %h", $time, k,
                     exp_o[127-16*k -: 16], out_data_o[127-16*k -: 16]);
          end
        end
      end
    end
  end

  task automatic send_rect(in_t a);
    int g;
    in_valid_i <= 1'b1;
    in_data_i  <= a;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    clip_q.push_back(clip_rect(a));
    n_sent++;
    g = pick_gap();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (clip_q.size() != 0) @(posedge clk_i);
    repeat (NSTG + 4) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [POS_BITS-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_ENABLE: sc_en     = val[0];
      CFG_LEFT:   sc_left   = val;
      CFG_TOP:    sc_top    = val;
      CFG_RIGHT:  sc_right  = val;
      CFG_BOTTOM: sc_bottom = val;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_scissor(logic en, int l, int t, int r, int b);
    drain();
    write_reg(CFG_LEFT, l[POS_BITS-1:0]);
    write_reg(CFG_TOP, t[POS_BITS-1:0]);
    write_reg(CFG_RIGHT, r[POS_BITS-1:0]);
    write_reg(CFG_BOTTOM, b[POS_BITS-1:0]);
    write_reg(CFG_ENABLE, {15'($urandom_range(0, 32767)), en});
  endtask

  function automatic in_t mk(int ux, int uy, int lx, int ly, int us, int ut, int ls, int lt);
    in_t a;
    a.ul_x = ux[15:0]; a.ul_y = uy[15:0]; a.lr_x = lx[15:0]; a.lr_y = ly[15:0];
    a.ul_s = us[15:0]; a.ul_t = ut[15:0]; a.lr_s = ls[15:0]; a.lr_t = lt[15:0];
    return a;
  endfunction

  function automatic in_t rand_rect();
    in_t a;
    int  ux, uy;
    a = {$urandom, $urandom, $urandom, $urandom};
    if ($urandom_range(0, 9) < 7) begin
      ux = int'(sc_left) + $signed($urandom_range(0, 80)) - 40;
      uy = int'(sc_top) + $signed($urandom_range(0, 80)) - 40;
      a.ul_x = ux[15:0];
      a.ul_y = uy[15:0];
      a.lr_x = 16'(ux + $urandom_range(0, 200));
      a.lr_y = 16'(uy + $urandom_range(0, 200));
    end
    return a;
  endfunction

  task automatic test_reset_passthrough();
    sc_en = 0; sc_left = 0; sc_top = 0; sc_right = 0; sc_bottom = 0;
    send_rect(mk(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
    send_rect(mk(100, 50, -100, -50, 1, 2, 3, 4));
    send_rect(mk(32767, 32767, -32768, -32768, 32767, -32768, -32768, 32767));
    send_rect('1);
  endtask

  task automatic test_clip_cases();
    set_scissor(1, 10, 20, 100, 200);
    send_rect(mk(30, 40, 50, 60, 100, 200, 300, 400));          // inside
    send_rect(mk(0, 0, 300, 400, 0, 0, 4096, 4096));            // clip all edges
    send_rect(mk(0, 30, 50, 60, -4096, 0, 4096, 8));            // left edge
    send_rect(mk(0, 0, 5, 300, 1, 1, 2, 2));                    // fully clipped
    send_rect(mk(40, 210, 50, 300, 1, 1, 2, 2));                // below
    send_rect(mk(5, 5, 5, 5, 7, 7, 8, 8));                      // zero span, hidden
    send_rect(mk(50, 50, 50, 50, -3, 3, 8, -8));                // zero span, visible
    send_rect(mk(60, 60, 40, 40, 1, 2, 3, 4));                  // inverted
    send_rect(mk(-32768, -32768, 32767, 32767, -32768, -32768, 32767, 32767));
    send_rect(mk(99, 199, 1000, 1000, 32767, 32767, -32768, -32768));
    send_rect(mk(100, 200, 100, 200, 32767, -32768, 32767, -32768));
    set_scissor(1, 30, 30, 20, 20);                             // inverted scissor
    send_rect(mk(0, 0, 50, 50, 1, 2, 3, 4));
    // full-range Q3.12 texcoords under a scissor box that covers all positions
    set_scissor(1, -32768, -32768, 32767, 32767);
    send_rect(mk(0, 0, 1, 1, 32767, -32768, -32768, 32767));
    send_rect(mk(-32768, 0, 32767, 0, 32767, -32768, -32768, 32767));
    drain();
    write_reg(cfg_idx_e'(5), 16'hffff);
    write_reg(cfg_idx_e'(7), 16'h1234);
    send_rect(mk(-10, -10, 10, 10, 100, -100, -100, 100));
  endtask

  task automatic test_random(int n, logic en, int l, int t, int r, int b);
    set_scissor(en, l, t, r, b);
    for (int i = 0; i < n; i++) send_rect(rand_rect());
  endtask

  task automatic test_pause_until_drained();
    for (int i = 0; i < 20; i++) send_rect(rand_rect());
    in_valid_i <= 1'b0;
    while (clip_q.size() != 0) @(posedge clk_i);
    for (int i = 0; i < 20; i++) send_rect(rand_rect());
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_passthrough();
    test_clip_cases();
    idle_on = 1'b0;
    test_random(60, 1, -50, -60, 70, 80);
    idle_on = 1'b1;
    test_random(90, 1, -50, -60, 70, 80);
    test_random(60, 0, 0, 0, 0, 0);
    test_random(80, 1, -32768, -32768, 32767, 32767);
    test_random(80, 1, 32000, -32768, 32767, -32000);
    test_random(80, 1, $signed($urandom_range(0, 400)) - 200, -7, 300, 9);
    test_pause_until_drained();
    test_random(40, 1, 0, 0, 0, 0);
    drain();
    $display("Sent %0d rectangles, checked %0d beats (%0d fully clipped),",
             n_sent, n_checked, n_hidden);
    $display("over pass-through, clipping, inverted and extreme scissor boxes.");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/sct_pkg.sv
rtl/sct_lane.sv
rtl/scissor_clip_textured_rect_top.sv
tb/sv/tb_scissor_clip_textured_rect_top.sv
